FILE: sv/pbw_pkg.sv
// Shared types and codes for the protobuf wire-format field parser.
package pbw_pkg;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIX64   = 3'd2,
        PH_FIX32   = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    localparam logic [2:0] KIND_VARINT  = 3'd0;
    localparam logic [2:0] KIND_FIX64   = 3'd1;
    localparam logic [2:0] KIND_FIX32   = 3'd2;
    localparam logic [2:0] KIND_LEN     = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_VARINT = 2'd1;
    localparam logic [1:0] ERR_BAD_WT     = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    // A varint holds at most ten bytes; the tenth sits at this count.
    localparam logic [3:0] VARINT_LAST_COUNT = 4'd9;
    localparam logic [3:0] FIX64_BYTES       = 4'd8;
    localparam logic [3:0] FIX32_BYTES       = 4'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [60:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] out_value;
        logic [7:0]  payload_byte;
        logic        field_end;
        logic [1:0]  error_code;
        logic        message_done;
    } result_t;

endpackage

FILE: sv/protobuf_wire_field_parser_unit.sv
// Top level of the protobuf wire-format field parser: input register, decode, result register.
// Takes one message byte per cycle and gives at most one result per byte. A byte passes an
// input register, the decode step against the running field state, and a result register, so
// a result reaches the output only after its byte has passed both registers. A byte that
// completes nothing yields no result. A stall on the result side holds the result register
// and, once the input register is also full, raises stall toward the byte source in the same
// cycle; otherwise a new byte is taken every cycle. No clearing pass follows reset.
module protobuf_wire_field_parser_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pbw_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output pbw_pkg::result_t  result
);

    logic             item_valid_reg;
    pbw_pkg::item_t   item_reg;
    logic             result_valid_reg;
    pbw_pkg::result_t result_reg;

    logic             out_free;
    logic             advance;
    logic             have;
    pbw_pkg::result_t step_result;

    assign out_free   = !result_valid_reg || !result_stall;
    assign advance    = item_valid_reg && out_free;
    assign item_stall = item_valid_reg && !out_free;

    pbw_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (item_reg),
        .have   (have),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= have;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && have)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: sv/pbw_core.sv
// Parser state registers and the per-byte decode step.
module pbw_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  pbw_pkg::item_t  item,
    output logic            have,
    output pbw_pkg::result_t result
);

    pbw_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [60:0] field_reg, field_next;
    logic [2:0]  wt_reg, wt_next;
    logic [63:0] remaining_reg, remaining_next;
    logic        dropping_reg, dropping_next;

    logic [7:0]  b;
    logic        last;
    logic [3:0]  n_var;
    logic [5:0]  var_shamt;
    logic [63:0] var_or;
    logic [2:0]  n_fix;
    logic [63:0] fix_or;
    logic [3:0]  fix_cnt;
    logic [63:0] rem_dec;

    logic [2:0]  kind;
    logic [1:0]  err;
    logic [7:0]  pbyte;
    logic [63:0] val;
    logic        fend;
    logic [60:0] fnum;
    logic [2:0]  wt;

    assign b    = item.in_byte;
    assign last = item.end_of_message;

    assign n_var     = (cnt_reg > pbw_pkg::VARINT_LAST_COUNT) ? pbw_pkg::VARINT_LAST_COUNT
                                                              : cnt_reg;
    assign var_shamt = 6'({2'b00, n_var} * 6'd7);
    assign var_or    = acc_reg | (64'(b[6:0]) << var_shamt);
    assign n_fix     = cnt_reg[2:0];
    assign fix_or    = acc_reg | (64'(b) << {n_fix, 3'b000});
    assign fix_cnt   = {1'b0, n_fix} + 4'd1;
    assign rem_dec   = (remaining_reg != 64'd0) ? remaining_reg - 64'd1 : 64'd0;

    always_comb
    begin
        unique case (phase_reg)
            pbw_pkg::PH_VARINT, pbw_pkg::PH_FIX64, pbw_pkg::PH_FIX32,
            pbw_pkg::PH_LEN, pbw_pkg::PH_PAYLOAD: phase_eff = phase_reg;
            default:                              phase_eff = pbw_pkg::PH_TAG;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_eff;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        field_next     = field_reg;
        wt_next        = wt_reg;
        remaining_next = remaining_reg;
        dropping_next  = dropping_reg;

        have  = 1'b0;
        kind  = pbw_pkg::KIND_VARINT;
        err   = pbw_pkg::ERR_NONE;
        pbyte = 8'd0;
        val   = 64'd0;
        fend  = 1'b0;
        fnum  = (phase_eff == pbw_pkg::PH_TAG) ? 61'd0 : field_reg;
        wt    = (phase_eff == pbw_pkg::PH_TAG) ? 3'd0 : wt_reg;

        if (dropping_reg)
        begin
            fnum = 61'd0;
            wt   = 3'd0;
        end
        else
        begin
            unique case (phase_eff)
                pbw_pkg::PH_TAG, pbw_pkg::PH_VARINT, pbw_pkg::PH_LEN:
                begin
                    if (cnt_reg >= pbw_pkg::VARINT_LAST_COUNT && b > 8'd1)
                    begin
                        err = pbw_pkg::ERR_BAD_VARINT;
                    end
                    else if (b[7])
                    begin
                        acc_next = var_or;
                        cnt_next = n_var + 4'd1;
                    end
                    else
                    begin
                        acc_next = 64'd0;
                        cnt_next = 4'd0;
                        if (phase_eff == pbw_pkg::PH_TAG)
                        begin
                            field_next = var_or[63:3];
                            wt_next    = var_or[2:0];
                            fnum       = var_or[63:3];
                            wt         = var_or[2:0];
                            unique case (var_or[2:0])
                                pbw_pkg::WT_VARINT: phase_next = pbw_pkg::PH_VARINT;
                                pbw_pkg::WT_FIX64:  phase_next = pbw_pkg::PH_FIX64;
                                pbw_pkg::WT_LEN:    phase_next = pbw_pkg::PH_LEN;
                                pbw_pkg::WT_FIX32:  phase_next = pbw_pkg::PH_FIX32;
                                default:            err = pbw_pkg::ERR_BAD_WT;
                            endcase
                        end
                        else if (phase_eff == pbw_pkg::PH_VARINT)
                        begin
                            have       = 1'b1;
                            kind       = pbw_pkg::KIND_VARINT;
                            val        = var_or;
                            fend       = 1'b1;
                            phase_next = pbw_pkg::PH_TAG;
                        end
                        else
                        begin
                            have = 1'b1;
                            kind = pbw_pkg::KIND_LEN;
                            val  = var_or;
                            if (var_or == 64'd0)
                            begin
                                fend       = 1'b1;
                                phase_next = pbw_pkg::PH_TAG;
                            end
                            else
                            begin
                                remaining_next = var_or;
                                phase_next     = pbw_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                pbw_pkg::PH_FIX64, pbw_pkg::PH_FIX32:
                begin
                    acc_next = fix_or;
                    cnt_next = fix_cnt;
                    if (fix_cnt >= ((phase_eff == pbw_pkg::PH_FIX64) ? pbw_pkg::FIX64_BYTES
                                                                      : pbw_pkg::FIX32_BYTES))
                    begin
                        have       = 1'b1;
                        kind       = (phase_eff == pbw_pkg::PH_FIX64) ? pbw_pkg::KIND_FIX64
                                                                      : pbw_pkg::KIND_FIX32;
                        val        = fix_or;
                        fend       = 1'b1;
                        acc_next   = 64'd0;
                        cnt_next   = 4'd0;
                        phase_next = pbw_pkg::PH_TAG;
                    end
                end
                default:
                begin
                    // payload byte: pass through and count down
                    have           = 1'b1;
                    kind           = pbw_pkg::KIND_PAYLOAD;
                    pbyte          = b;
                    remaining_next = rem_dec;
                    if (rem_dec == 64'd0)
                    begin
                        fend       = 1'b1;
                        phase_next = pbw_pkg::PH_TAG;
                    end
                end
            endcase

            if (err != pbw_pkg::ERR_NONE)
            begin
                have  = 1'b1;
                kind  = pbw_pkg::KIND_VARINT;
                val   = 64'd0;
                pbyte = 8'd0;
                fend  = 1'b0;
                if (!last)
                begin
                    dropping_next = 1'b1;
                end
            end
            else if (last && !(have && fend))
            begin
                err = pbw_pkg::ERR_TRUNCATED;
                if (!have)
                begin
                    have  = 1'b1;
                    kind  = pbw_pkg::KIND_VARINT;
                    val   = 64'd0;
                    pbyte = 8'd0;
                end
                fend = 1'b0;
            end
        end

        // end of message: report and return to the reset state
        if (last)
        begin
            have           = 1'b1;
            phase_next     = pbw_pkg::PH_TAG;
            acc_next       = 64'd0;
            cnt_next       = 4'd0;
            field_next     = 61'd0;
            wt_next        = 3'd0;
            remaining_next = 64'd0;
            dropping_next  = 1'b0;
        end

        result.kind         = kind;
        result.field_number = fnum;
        result.wire_type    = wt;
        result.out_value    = val;
        result.payload_byte = pbyte;
        result.field_end    = fend;
        result.error_code   = err;
        result.message_done = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pbw_pkg::PH_TAG;
            acc_reg       <= 64'd0;
            cnt_reg       <= 4'd0;
            field_reg     <= 61'd0;
            wt_reg        <= 3'd0;
            remaining_reg <= 64'd0;
            dropping_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            field_reg     <= field_next;
            wt_reg        <= wt_next;
            remaining_reg <= remaining_next;
            dropping_reg  <= dropping_next;
        end
    end

endmodule

FILE: sv/pbw_checker.sv
// Port-level checks for the protobuf wire-format field parser, bound to the top level.
module pbw_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input pbw_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input pbw_pkg::result_t result
);

    // hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result transaction changed");

    // hold a stalled input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled input transaction changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == pbw_pkg::KIND_PAYLOAD |-> result.out_value == 64'd0)
        else $error("payload byte carries a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != pbw_pkg::KIND_PAYLOAD |-> result.payload_byte == 8'd0)
        else $error("non-payload result carries a payload byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error_code != pbw_pkg::ERR_NONE |-> !result.field_end)
        else $error("errored result marks field end");

endmodule

bind protobuf_wire_field_parser_unit pbw_checker u_pbw_checker (.*);
